[rtl/core/length_crc32_frame_checker_assert.svh]
// Assertion macros used by the frame checker top level.
`ifndef LENGTH_CRC32_FRAME_CHECKER_ASSERT_SVH
`define LENGTH_CRC32_FRAME_CHECKER_ASSERT_SVH

// Same-cycle implication, sampled on clock, quiet during reset.
`define LCFC_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, quiet during reset.
`define LCFC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/lcfc_pkg.sv]
// Types and constants of the length-prefixed CRC-32 frame checker.
`default_nettype none

package lcfc_pkg;

   // Result status codes
   typedef enum logic [1:0] {
      ST_ACCEPTED     = 2'd0,
      ST_CRC_MISMATCH = 2'd1,
      ST_NOT_FRAME    = 2'd2
   } status_type;

   localparam logic [31:0] CRC_POLY     = 32'hedb88320;
   localparam logic [31:0] CRC_INIT     = 32'hffffffff;
   localparam logic [31:0] START_RESET  = 32'h02020202;

   // Frame layout offsets in bytes
   localparam int START_BYTES    = 4;
   localparam int HEADER_BYTES   = 8;
   localparam int LENGTH_LAST    = 7;
   localparam int FRAME_OVERHEAD = 12;

endpackage

`default_nettype wire

[rtl/core/lcfc_req_if.sv]
// Request channel: one datagram byte with its end flag.
`default_nettype none

interface lcfc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

[rtl/core/lcfc_rsp_if.sv]
// Response channel: frame check result per datagram.
`default_nettype none

interface lcfc_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [31:0] length_field;
   logic        short_frame;
   logic [31:0] received_crc;
   logic [31:0] computed_crc;
   logic [31:0] frame_count;

   modport source (output valid, output status, output length_field, output short_frame,
                   output received_crc, output computed_crc, output frame_count,
                   input ready);
   modport sink   (input valid, input status, input length_field, input short_frame,
                   input received_crc, input computed_crc, input frame_count,
                   output ready);
endinterface

`default_nettype wire

[rtl/core/length_crc32_frame_checker.sv]
// Top level of the length-prefixed CRC-32 frame checker.
//
//   channel | direction | payload                                        | handshake
//   req     | in        | data_byte, last_byte                           | valid/ready
//   rsp     | out       | status, length_field, short_frame,             | valid/ready
//           |           | received_crc, computed_crc, frame_count        |
//   csr     | in        | start_pattern                                  | csr_wr_en
//
// One request per cycle sustained while no final byte waits on a stalled response. The final
// request is captured in the input register, and the response register loads as that byte
// leaves it. Reset is synchronous and active high and restores the start
// pattern to 0x02020202. A stalled response holds the pipeline only when a final
// byte needs the response register; other bytes keep flowing.
`default_nettype none

module length_crc32_frame_checker #(
   parameter int MAX_DATAGRAM = 65536
) (
   input  wire logic   clock,
   input  wire logic   reset,
   lcfc_req_if.sink    req,
   lcfc_rsp_if.source  rsp,
   input  wire logic        csr_wr_en,
   input  wire logic [31:0] csr_wr_data
);

`include "length_crc32_frame_checker_assert.svh"

   localparam int IDX_W = $clog2(MAX_DATAGRAM + 1);
   localparam logic [IDX_W-1:0] IDX_MAX      = IDX_W'(MAX_DATAGRAM);
   localparam logic [IDX_W-1:0] IDX_START    = IDX_W'(lcfc_pkg::START_BYTES);
   localparam logic [IDX_W-1:0] IDX_HEADER   = IDX_W'(lcfc_pkg::HEADER_BYTES);
   localparam logic [IDX_W-1:0] IDX_LEN_LAST = IDX_W'(lcfc_pkg::LENGTH_LAST);
   localparam logic [IDX_W-1:0] IDX_OVERHEAD = IDX_W'(lcfc_pkg::FRAME_OVERHEAD);

   // Configuration
   logic [31:0] start_ff, start_in;

   // Input register
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff, s1_byte_in;
   logic       s1_last_ff, s1_last_in;

   // Per-datagram state
   logic [IDX_W-1:0] idx_ff, idx_in, idx_step;
   logic [31:0]      hdr_ff, hdr_in, hdr_step;
   logic [32:0]      exp_ff, exp_in, exp_step;
   logic [31:0]      tail_ff, tail_in, tail_step;
   logic [31:0]      crc_ff, crc_in, crc_step;
   logic             mism_ff, mism_in, mism_step;
   logic             span_ff, span_in, span_step;
   logic [31:0]      acc_ff, acc_in;

   // Response register
   logic                   rsp_valid_ff, rsp_valid_in;
   lcfc_pkg::status_type   rsp_status_ff, rsp_status_in;
   logic [31:0]            rsp_len_ff, rsp_len_in;
   logic                   rsp_short_ff, rsp_short_in;
   logic [31:0]            rsp_rcrc_ff, rsp_rcrc_in;
   logic [31:0]            rsp_ccrc_ff, rsp_ccrc_in;
   logic [31:0]            rsp_cnt_ff, rsp_cnt_in;

   logic             out_free, s1_adv, req_take;
   logic [IDX_W:0]   idx_plus;
   logic [31:0]      crc_next_byte;
   logic             not_frame, crc_eq, frame_end, frame_good;

   lcfc_crc_byte u_crc (
      .crc_in  (crc_ff),
      .data_in (tail_ff[7:0]),
      .crc_out (crc_next_byte)
   );

   // Handshake: advance the input register when the response slot allows
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign s1_adv    = s1_valid_ff && (!s1_last_ff || out_free);
   assign req.ready = !s1_valid_ff || s1_adv;
   assign req_take  = req.valid && req.ready;
   assign frame_end = s1_adv && s1_last_ff;

   // Capture request and configuration
   always_comb begin
      start_in    = csr_wr_en ? csr_wr_data : start_ff;
      s1_valid_in = req_take ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
      s1_byte_in  = req_take ? req.data_byte : s1_byte_ff;
      s1_last_in  = req_take ? req.last_byte : s1_last_ff;
   end

   // Apply one byte to the datagram state
   always_comb begin
      idx_plus  = {1'b0, idx_ff} + {{IDX_W{1'b0}}, 1'b1};
      idx_step  = idx_ff;
      hdr_step  = hdr_ff;
      exp_step  = exp_ff;
      tail_step = tail_ff;
      crc_step  = crc_ff;
      mism_step = mism_ff;
      span_step = span_ff;
      if (idx_ff < IDX_MAX) begin
         if (idx_ff < IDX_START) begin
            if (s1_byte_ff != start_ff[{idx_ff[1:0], 3'b000} +: 8]) begin
               mism_step = 1'b1;
            end
         end else if (idx_ff < IDX_HEADER) begin
            hdr_step[{idx_ff[1:0], 3'b000} +: 8] = s1_byte_ff;
            if (idx_ff == IDX_LEN_LAST) begin
               exp_step = {1'b0, hdr_step} + 33'(lcfc_pkg::FRAME_OVERHEAD);
            end
         end
         if (!span_ff) begin
            if (idx_ff >= IDX_OVERHEAD) begin
               crc_step = crc_next_byte;
            end
            tail_step = {s1_byte_ff, tail_ff[31:8]};
            if (idx_ff >= IDX_HEADER && 33'(idx_plus) >= exp_ff) begin
               span_step = 1'b1;
            end
         end
         idx_step = idx_plus[IDX_W-1:0];
      end
   end

   // Judge the datagram on its final byte
   assign not_frame  = (idx_step <= IDX_OVERHEAD) || mism_step;
   assign crc_eq     = (tail_step == ~crc_step);
   assign frame_good = !not_frame && crc_eq;

   // Advance or clear the datagram state
   always_comb begin
      idx_in  = idx_ff;
      hdr_in  = hdr_ff;
      exp_in  = exp_ff;
      tail_in = tail_ff;
      crc_in  = crc_ff;
      mism_in = mism_ff;
      span_in = span_ff;
      acc_in  = acc_ff;
      if (s1_adv) begin
         if (s1_last_ff) begin
            idx_in  = '0;
            hdr_in  = '0;
            exp_in  = '0;
            tail_in = '0;
            crc_in  = lcfc_pkg::CRC_INIT;
            mism_in = 1'b0;
            span_in = 1'b0;
            if (frame_good) begin
               acc_in = acc_ff + 32'd1;
            end
         end else begin
            idx_in  = idx_step;
            hdr_in  = hdr_step;
            exp_in  = exp_step;
            tail_in = tail_step;
            crc_in  = crc_step;
            mism_in = mism_step;
            span_in = span_step;
         end
      end
   end

   // Load or drain the response register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_status_in = rsp_status_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_short_in  = rsp_short_ff;
      rsp_rcrc_in   = rsp_rcrc_ff;
      rsp_ccrc_in   = rsp_ccrc_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      if (frame_end) begin
         rsp_valid_in = 1'b1;
         rsp_cnt_in   = acc_in;
         if (not_frame) begin
            rsp_status_in = lcfc_pkg::ST_NOT_FRAME;
            rsp_len_in    = '0;
            rsp_short_in  = 1'b0;
            rsp_rcrc_in   = '0;
            rsp_ccrc_in   = '0;
         end else begin
            rsp_status_in = crc_eq ? lcfc_pkg::ST_ACCEPTED : lcfc_pkg::ST_CRC_MISMATCH;
            rsp_len_in    = hdr_step;
            rsp_short_in  = (33'(idx_step) < exp_step);
            rsp_rcrc_in   = tail_step;
            rsp_ccrc_in   = ~crc_step;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff     <= lcfc_pkg::START_RESET;
         s1_valid_ff  <= 1'b0;
         idx_ff       <= '0;
         hdr_ff       <= '0;
         exp_ff       <= '0;
         tail_ff      <= '0;
         crc_ff       <= lcfc_pkg::CRC_INIT;
         mism_ff      <= 1'b0;
         span_ff      <= 1'b0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         start_ff     <= start_in;
         s1_valid_ff  <= s1_valid_in;
         idx_ff       <= idx_in;
         hdr_ff       <= hdr_in;
         exp_ff       <= exp_in;
         tail_ff      <= tail_in;
         crc_ff       <= crc_in;
         mism_ff      <= mism_in;
         span_ff      <= span_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      s1_byte_ff    <= s1_byte_in;
      s1_last_ff    <= s1_last_in;
      rsp_status_ff <= rsp_status_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_short_ff  <= rsp_short_in;
      rsp_rcrc_ff   <= rsp_rcrc_in;
      rsp_ccrc_ff   <= rsp_ccrc_in;
      rsp_cnt_ff    <= rsp_cnt_in;
   end

   // Drive the response channel
   assign rsp.valid          = rsp_valid_ff;
   assign rsp.status         = rsp_status_ff;
   assign rsp.length_field   = rsp_len_ff;
   assign rsp.short_frame    = rsp_short_ff;
   assign rsp.received_crc   = rsp_rcrc_ff;
   assign rsp.computed_crc   = rsp_ccrc_ff;
   assign rsp.frame_count    = rsp_cnt_ff;

   // Checks
   `LCFC_ASSERT_NOW(a_accept_crc_match, rsp_valid_ff && rsp_status_ff == lcfc_pkg::ST_ACCEPTED, rsp_rcrc_ff == rsp_ccrc_ff, "accepted frame with differing CRCs")
   `LCFC_ASSERT_NOW(a_not_frame_zero, rsp_valid_ff && rsp_status_ff == lcfc_pkg::ST_NOT_FRAME, rsp_len_ff == 32'd0 && rsp_ccrc_ff == 32'd0 && !rsp_short_ff, "non-frame result carries data")
   `LCFC_ASSERT_NEXT(a_clear_after_end, frame_end, idx_ff == '0 && crc_ff == lcfc_pkg::CRC_INIT && !span_ff && !mism_ff, "datagram state not cleared")
   `LCFC_ASSERT_NEXT(a_count_step, frame_end && frame_good, acc_ff == $past(acc_ff) + 32'd1 && rsp_cnt_ff == acc_ff, "accepted count did not advance")

endmodule

`default_nettype wire

[rtl/core/lcfc_crc_byte.sv]
// Byte-wide reflected CRC-32 update, eight bit steps unrolled.
`default_nettype none

module lcfc_crc_byte (
   input  wire logic [31:0] crc_in,
   input  wire logic [7:0]  data_in,
   output logic [31:0]      crc_out
);

   // Fold the byte in, then shift out eight bits
   always_comb begin
      logic [31:0] c;
      c = crc_in ^ {24'd0, data_in};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ lcfc_pkg::CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      crc_out = c;
   end

endmodule

`default_nettype wire
